// ===== hw/rtl/qvr_pkg.sv =====
// Package with widths, register indexes and helpers for the quaternion point rotator.
package qvr_pkg;

  // Field widths
  localparam int unsigned VEC_W   = 16;              // input coordinate
  localparam int unsigned QUAT_W  = 16;              // quaternion part, Q1.14
  localparam int unsigned ROT_W   = 18;              // output coordinate
  localparam int unsigned M_W     = VEC_W + QUAT_W;  // first products
  localparam int unsigned P_W     = M_W + 2;         // p = q*(0,v), Q14
  localparam int unsigned N_W     = P_W + QUAT_W;    // second products
  localparam int unsigned R_W     = N_W + 2;         // r = p*conj(q), Q28
  localparam int unsigned FRAC_W  = 28;              // fraction bits of r
  localparam int unsigned RND_W   = R_W + 1;         // r plus rounding half
  localparam int unsigned INT_W   = RND_W - FRAC_W;  // integer part after shift

  // Stream and register port widths
  localparam int unsigned IN_TDATA_W  = 3 * VEC_W;
  localparam int unsigned OUT_TDATA_W = ((3 * ROT_W + 7) / 8) * 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 4;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } reg_idx_t;

  // Reset value of the real part: 1.0 in Q1.14
  localparam logic signed [QUAT_W-1:0] QUAT_W_RESET = QUAT_W'(16384);

  localparam logic signed [ROT_W-1:0] ROT_MAX = {1'b0, {(ROT_W-1){1'b1}}};
  localparam logic signed [ROT_W-1:0] ROT_MIN = {1'b1, {(ROT_W-1){1'b0}}};

  // Round a Q28 value half up to its integer part
  function automatic logic signed [INT_W-1:0] round_q28(input logic signed [R_W-1:0] s);
    logic signed [RND_W-1:0] sum;
    sum = RND_W'(s) + RND_W'(64'sd1 <<< (FRAC_W - 1));
    return sum[RND_W-1:FRAC_W];
  endfunction

  // Saturated 18-bit value of a rounded integer
  function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [INT_W-1:0] v);
    logic signed [ROT_W-1:0] res;
    if (v > INT_W'(ROT_MAX)) begin
      res = ROT_MAX;
    end else if (v < INT_W'(ROT_MIN)) begin
      res = ROT_MIN;
    end else begin
      res = v[ROT_W-1:0];
    end
    return res;
  endfunction

  // Set when the rounded integer does not fit in 18 bits
  function automatic logic is_clip(input logic signed [INT_W-1:0] v);
    return (v > INT_W'(ROT_MAX)) || (v < INT_W'(ROT_MIN));
  endfunction

endpackage

// ===== hw/rtl/quaternion_vector_rotation.sv =====
// Streaming rotation of 3-D points by a quaternion: q * (0,v) * conj(q).
//
// Usage:
//   Points enter on the in_ stream, one transaction per point, vec_x in the
//   low 16 bits of in_tdata, then vec_y and vec_z. Each point gives exactly
//   one transaction on the out_ stream with rot_x, rot_y, rot_z (18 bits
//   each, rounded half up and saturated) and the clipped flag on out_tuser.
//   The quaternion (Q1.14, no normalization) sits in four APB registers at
//   byte addresses 0, 4, 8 and 12 (w, x, y, z); write them only while no
//   point is in flight.
// Pipeline and throughput:
//   Five register stages (products, sums, products, sums, round/saturate)
//   lie between a taken point and its result on the outputs.
//   One point is accepted every cycle while the output is not stalled; the
//   two multiplier banks are the stages that set that figure, each fully parallel.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and loads q = 1.
// Stalls:
//   Each stage holds its transaction while the next one is full and cannot
//   move; empty stages keep filling, so input is taken until the pipe is full.
module quaternion_vector_rotation (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [qvr_pkg::IN_TDATA_W-1:0]      in_tdata,   // vec_x, vec_y, vec_z
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [qvr_pkg::OUT_TDATA_W-1:0]     out_tdata,  // rot_x, rot_y, rot_z, zero pad
  output logic                                out_tuser,  // clipped
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [qvr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [qvr_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import qvr_pkg::*;

  localparam int unsigned NSTG = 5;

  // Quaternion registers
  logic signed [QUAT_W-1:0] qw_r, qx_r, qy_r, qz_r;
  reg_idx_t                 cfg_idx;
  logic                     cfg_wr;
  logic signed [QUAT_W-1:0] cfg_val;

  // Pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;

  // Pipeline data
  logic signed [VEC_W-1:0] vx, vy, vz;
  logic signed [M_W-1:0]   m_r   [12];
  logic signed [P_W-1:0]   p_r   [4];
  logic signed [N_W-1:0]   n_r   [12];
  logic signed [R_W-1:0]   r_r   [3];
  logic signed [ROT_W-1:0] rot_r [3];
  logic                    clip_r;

  logic signed [INT_W-1:0] rint  [3];

  // Decode register writes
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_val    = cfg_pwdata[QUAT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r <= QUAT_W_RESET;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_QUAT_W: qw_r <= cfg_val;
        REG_QUAT_X: qx_r <= cfg_val;
        REG_QUAT_Y: qy_r <= cfg_val;
        REG_QUAT_Z: qz_r <= cfg_val;
        default:    qw_r <= qw_r;
      endcase
    end
  end

  // Read back, sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_QUAT_W: cfg_prdata = CFG_DATA_W'(qw_r);
      REG_QUAT_X: cfg_prdata = CFG_DATA_W'(qx_r);
      REG_QUAT_Y: cfg_prdata = CFG_DATA_W'(qy_r);
      REG_QUAT_Z: cfg_prdata = CFG_DATA_W'(qz_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Ready chain: a stage takes a transaction when it is empty or moves on
  always_comb begin
    rdy[NSTG] = out_tready;
    for (int k = int'(NSTG) - 1; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign vx = in_tdata[VEC_W-1:0];
  assign vy = in_tdata[2*VEC_W-1:VEC_W];
  assign vz = in_tdata[3*VEC_W-1:2*VEC_W];

  // Stage 1: products of q and v
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m_r[0]  <= qx_r * vx;
      m_r[1]  <= qy_r * vy;
      m_r[2]  <= qz_r * vz;
      m_r[3]  <= qw_r * vx;
      m_r[4]  <= qy_r * vz;
      m_r[5]  <= qz_r * vy;
      m_r[6]  <= qw_r * vy;
      m_r[7]  <= qx_r * vz;
      m_r[8]  <= qz_r * vx;
      m_r[9]  <= qw_r * vz;
      m_r[10] <= qx_r * vy;
      m_r[11] <= qy_r * vx;
    end
  end

  // Stage 2: p = q * (0,v)
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_r[0] <= -P_W'(m_r[0]) - P_W'(m_r[1]) - P_W'(m_r[2]);
      p_r[1] <=  P_W'(m_r[3]) + P_W'(m_r[4]) - P_W'(m_r[5]);
      p_r[2] <=  P_W'(m_r[6]) - P_W'(m_r[7]) + P_W'(m_r[8]);
      p_r[3] <=  P_W'(m_r[9]) + P_W'(m_r[10]) - P_W'(m_r[11]);
    end
  end

  // Stage 3: products of p and q
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      n_r[0]  <= p_r[0] * qx_r;
      n_r[1]  <= p_r[1] * qw_r;
      n_r[2]  <= p_r[2] * qz_r;
      n_r[3]  <= p_r[3] * qy_r;
      n_r[4]  <= p_r[0] * qy_r;
      n_r[5]  <= p_r[1] * qz_r;
      n_r[6]  <= p_r[2] * qw_r;
      n_r[7]  <= p_r[3] * qx_r;
      n_r[8]  <= p_r[0] * qz_r;
      n_r[9]  <= p_r[1] * qy_r;
      n_r[10] <= p_r[2] * qx_r;
      n_r[11] <= p_r[3] * qw_r;
    end
  end

  // Stage 4: vector part of p * conj(q), Q28
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      r_r[0] <= R_W'(n_r[1]) + R_W'(n_r[3]) - R_W'(n_r[0]) - R_W'(n_r[2]);
      r_r[1] <= R_W'(n_r[5]) + R_W'(n_r[6]) - R_W'(n_r[4]) - R_W'(n_r[7]);
      r_r[2] <= R_W'(n_r[10]) + R_W'(n_r[11]) - R_W'(n_r[8]) - R_W'(n_r[9]);
    end
  end

  // Stage 5: round half up, saturate, flag clipping
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rint[c] = round_q28(r_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < 3; c++) begin
        rot_r[c] <= sat_rot(rint[c]);
      end
      clip_r <= is_clip(rint[0]) | is_clip(rint[1]) | is_clip(rint[2]);
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = OUT_TDATA_W'({rot_r[2], rot_r[1], rot_r[0]});
  assign out_tuser  = clip_r;

  // An accepted transaction lands in the first stage
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transaction missing from first stage");

  // A stalled stage keeps its transaction and its data
  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !rdy[1]) |=> (vld_r[0] && $stable(p_r[0]) && $stable(m_r[0])))
    else $error("first stage lost data under stall");

  // Clipped results sit at a saturation bound
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (rot_r[0] == ROT_MAX || rot_r[0] == ROT_MIN ||
       rot_r[1] == ROT_MAX || rot_r[1] == ROT_MIN ||
       rot_r[2] == ROT_MAX || rot_r[2] == ROT_MIN))
    else $error("clipped flag without a saturated coordinate");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

endmodule
